@@ hw/rtl/ssc_pkg.sv @@
// Shared types and constants for the segment stroke coverage block.
// Used by ssc_div, ssc_sqrt and segment_stroke_coverage_top; depends on nothing.
`default_nettype none
package ssc_pkg;

   localparam int COORD_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF   = 4;

   localparam int RADIUS_W  = 16;
   localparam int THRESH_W  = 8;
   localparam int CSR_IDX_W = 1;
   localparam int COV_W     = 9;
   localparam int RSP_W     = 16;

   // Projection ratio T carries this many fraction bits.
   localparam int T_BITS    = 30;
   localparam int QUO_W     = T_BITS + 1;
   localparam int QUO_LO_W  = 16;
   localparam int QUO_HI_W  = QUO_W - QUO_LO_W;

   // Distances are in units of 1/256 pixel.
   localparam int DIST_FRAC = 8;

   localparam logic [COV_W-1:0] COV_FULL = 9'd256;
   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd16;
   localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd1;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_STROKE_RADIUS   = 1'b0,
      REG_DEGEN_THRESHOLD = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic valid;
      logic force_zero;
   } ctl_type;

endpackage
`default_nettype wire

@@ hw/rtl/ssc_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ssc_pkg for the control struct.
`default_nettype none
module ssc_div #(
   parameter int NUM_W  = 34,
   parameter int QW     = ssc_pkg::QUO_W,
   parameter int SIDE_W = 68
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire ssc_pkg::ctl_type    in_ctl,
   input  wire logic [NUM_W-1:0]    in_num,
   input  wire logic [NUM_W-1:0]    in_den,
   input  wire logic [SIDE_W-1:0]   in_side,
   output ssc_pkg::ctl_type         out_ctl,
   output logic [QW-1:0]            out_quo,
   output logic [SIDE_W-1:0]        out_side
);

   ssc_pkg::ctl_type   ctl_ff  [QW];
   logic [NUM_W-1:0]   rem_ff  [QW];
   logic [NUM_W-1:0]   den_ff  [QW];
   logic [QW-1:0]      quo_ff  [QW];
   logic [SIDE_W-1:0]  side_ff [QW];

   for (genvar j = 0; j < QW; j++) begin : g_stage
      ssc_pkg::ctl_type  ctl_src;
      logic [NUM_W:0]    rem_src;
      logic [NUM_W-1:0]  den_src;
      logic [QW-1:0]     quo_src;
      logic [SIDE_W-1:0] side_src;
      logic              ge;
      logic [NUM_W:0]    rem_dif;
      logic [NUM_W-1:0]  rem_in;
      logic [QW-1:0]     quo_in;

      if (j == 0) begin : g_first
         // The numerator never exceeds the divisor, so the top bit needs no shift.
         assign ctl_src  = in_ctl;
         assign rem_src  = {1'b0, in_num};
         assign den_src  = in_den;
         assign quo_src  = '0;
         assign side_src = in_side;
      end else begin : g_next
         assign ctl_src  = ctl_ff[j-1];
         assign rem_src  = {rem_ff[j-1], 1'b0};
         assign den_src  = den_ff[j-1];
         assign quo_src  = quo_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      always_comb begin
         ge      = rem_src >= {1'b0, den_src};
         rem_dif = rem_src - {1'b0, den_src};
         rem_in  = ge ? rem_dif[NUM_W-1:0] : rem_src[NUM_W-1:0];
         quo_in  = {quo_src[QW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[j] <= '0;
         end else if (en) begin
            ctl_ff[j] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_src;
            quo_ff[j]  <= quo_in;
            side_ff[j] <= side_src;
         end
      end
   end

   assign out_ctl  = ctl_ff[QW-1];
   assign out_quo  = quo_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule
`default_nettype wire

@@ hw/rtl/ssc_sqrt.sv @@
// Pipelined integer square root, one root bit per stage.
// Depends on ssc_pkg for the control struct.
`default_nettype none
module ssc_sqrt #(
   parameter int IN_W = 42
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               en,
   input  wire ssc_pkg::ctl_type   in_ctl,
   input  wire logic [IN_W-1:0]    in_val,
   output ssc_pkg::ctl_type        out_ctl,
   output logic [IN_W/2-1:0]       out_root
);

   localparam int RW  = IN_W / 2;
   localparam int RMW = RW + 3;

   ssc_pkg::ctl_type ctl_ff  [RW];
   logic [IN_W-1:0]  val_ff  [RW];
   logic [RMW-1:0]   rem_ff  [RW];
   logic [RW-1:0]    root_ff [RW];

   for (genvar i = 0; i < RW; i++) begin : g_stage
      ssc_pkg::ctl_type ctl_src;
      logic [IN_W-1:0]  val_src;
      logic [RMW-1:0]   rem_src;
      logic [RW-1:0]    root_src;
      logic [RMW+1:0]   rem_cat;
      logic [RMW-1:0]   rem_try;
      logic [RMW-1:0]   trial;
      logic             ge;

      if (i == 0) begin : g_first
         assign ctl_src  = in_ctl;
         assign val_src  = in_val;
         assign rem_src  = '0;
         assign root_src = '0;
      end else begin : g_next
         assign ctl_src  = ctl_ff[i-1];
         assign val_src  = val_ff[i-1];
         assign rem_src  = rem_ff[i-1];
         assign root_src = root_ff[i-1];
      end

      always_comb begin
         // Bring down the next pair of radicand bits and try root*4 + 1.
         rem_cat = {rem_src, val_src[IN_W-1 -: 2]};
         rem_try = rem_cat[RMW-1:0];
         trial   = {1'b0, root_src, 2'b01};
         ge      = rem_try >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[i] <= '0;
         end else if (en) begin
            ctl_ff[i] <= ctl_src;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            val_ff[i]  <= val_src << 2;
            rem_ff[i]  <= ge ? rem_try - trial : rem_try;
            root_ff[i] <= {root_src[RW-2:0], ge};
         end
      end
   end

   assign out_ctl  = ctl_ff[RW-1];
   assign out_root = root_ff[RW-1];

endmodule
`default_nettype wire

@@ hw/rtl/segment_stroke_coverage_top.sv @@
// Top level of the segment stroke coverage block: input stages, divider,
// partial product multiply, square root and the coverage ramp.
// Depends on ssc_pkg, ssc_div and ssc_sqrt.
//
//   Channel   Direction  Handshake              Content
//   req_      in         req_tvalid/req_tready  pixel, start and end point words
//   rsp_      out        rsp_tvalid/rsp_tready  coverage word
//   csr_      in         csr_wr_en              register index and write data
//
// A new word can enter in every cycle unless the output stalls. A word passes the
// input stages, the 31 divider stages (one per quotient bit), the partial product
// and radicand stages, the RW square root stages and the output register, where
// RW is half the radicand width (21 for 16-bit coordinates with 4 fraction bits).
// Reset clears all valid bits and loads the register reset values.
// When the output register holds a word that is not taken, the whole pipeline
// holds, so nothing is lost or repeated; bubbles already in it stay in place.
`default_nettype none
module segment_stroke_coverage_top #(
   parameter int COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = ssc_pkg::FRAC_BITS_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // pixel_x, pixel_y, start_x, start_y, end_x, end_y from the lowest bit up
   input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // coverage in the lowest 9 bits, zeros above
   output logic [ssc_pkg::RSP_W-1:0]                  rsp_tdata,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   input  wire logic                                  csr_wr_en,
   input  wire logic [ssc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  wire logic [ssc_pkg::RADIUS_W-1:0]          csr_wdata
);

   localparam int CW   = COORD_WIDTH;
   localparam int DW   = CW + 1;          // coordinate differences
   localparam int SQW  = 2 * CW + 2;      // squared lengths
   localparam int KW   = 2 * CW + 3;      // signed dot product
   localparam int CMPW = SQW + 8;         // degenerate test
   localparam int KLW  = SQW / 2;
   localparam int KHW  = SQW - KLW;
   localparam int PW   = SQW + ssc_pkg::QUO_W;
   localparam int SIW  = SQW + 2 * ssc_pkg::DIST_FRAC - 2 * FRAC_BITS;
   localparam int RW   = SIW / 2;
   localparam int RADW = ssc_pkg::RADIUS_W + ssc_pkg::DIST_FRAC;
   localparam int XW   = ((RADW > RW) ? RADW : RW) + 2;

   // Configuration registers.
   logic [ssc_pkg::RADIUS_W-1:0] radius_ff;
   logic [ssc_pkg::THRESH_W-1:0] thresh_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= ssc_pkg::RADIUS_RESET;
         thresh_ff <= ssc_pkg::THRESH_RESET;
      end else if (csr_wr_en) begin
         case (ssc_pkg::reg_index_type'(csr_index))
            ssc_pkg::REG_STROKE_RADIUS:   radius_ff <= csr_wdata;
            ssc_pkg::REG_DEGEN_THRESHOLD: thresh_ff <= csr_wdata[ssc_pkg::THRESH_W-1:0];
            default: ;
         endcase
      end
   end

   // The whole pipeline moves whenever the output register can take a word.
   // No word is taken while reset is held.
   logic out_valid_ff;
   logic adv;
   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv && !reset;

   // Stage 1: differences from the start point.
   logic signed [CW-1:0] px, py, ax, ay, bx, by;
   assign px = req_tdata[0*CW +: CW];
   assign py = req_tdata[1*CW +: CW];
   assign ax = req_tdata[2*CW +: CW];
   assign ay = req_tdata[3*CW +: CW];
   assign bx = req_tdata[4*CW +: CW];
   assign by = req_tdata[5*CW +: CW];

   ssc_pkg::ctl_type     ctl1_ff, ctl1_in;
   logic signed [DW-1:0] ex_ff, ey_ff, sx_ff, sy_ff;

   assign ctl1_in = '{valid: req_tvalid, force_zero: 1'b0};

   // Stage 2: the six products.
   ssc_pkg::ctl_type       ctl2_ff;
   logic signed [2*DW-1:0] sxx_ff, syy_ff, exx_ff, eyy_ff, exs_ff, eys_ff;

   // Stage 3: squared lengths and dot product.
   ssc_pkg::ctl_type     ctl3_ff;
   logic [SQW-1:0]       len_ff, qsq_ff;
   logic signed [KW-1:0] dot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= ctl1_in;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ex_ff  <= DW'(px) - DW'(ax);
         ey_ff  <= DW'(py) - DW'(ay);
         sx_ff  <= DW'(bx) - DW'(ax);
         sy_ff  <= DW'(by) - DW'(ay);
         sxx_ff <= sx_ff * sx_ff;
         syy_ff <= sy_ff * sy_ff;
         exx_ff <= ex_ff * ex_ff;
         eyy_ff <= ey_ff * ey_ff;
         exs_ff <= ex_ff * sx_ff;
         eys_ff <= ey_ff * sy_ff;
         len_ff <= sxx_ff[SQW-1:0] + syy_ff[SQW-1:0];
         qsq_ff <= exx_ff[SQW-1:0] + eyy_ff[SQW-1:0];
         dot_ff <= KW'(exs_ff) + KW'(eys_ff);
      end
   end

   // Stage 4: dot test and projection range check. A dot sends a zero
   // numerator, so the product after the divider is zero and M equals Q.
   logic [CMPW-1:0] len_scaled, thr_scaled;
   logic            is_dot, dot_neg, dot_big;
   ssc_pkg::ctl_type ctl4_in, ctl4_ff;
   logic [SQW-1:0]   num_in, num_ff, den_ff, q4_ff;

   always_comb begin
      len_scaled = {len_ff, 8'd0};
      thr_scaled = CMPW'(thresh_ff) << (2 * FRAC_BITS);
      is_dot     = (len_ff == '0) || (len_scaled < thr_scaled);
      dot_neg    = dot_ff[KW-1];
      dot_big    = !dot_neg && (dot_ff[KW-2:0] > (KW-1)'(len_ff));
      ctl4_in    = '{valid: ctl3_ff.valid, force_zero: !is_dot && (dot_neg || dot_big)};
      num_in     = is_dot ? '0 : dot_ff[SQW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl4_ff <= '0;
      end else if (adv) begin
         ctl4_ff <= ctl4_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num_ff <= num_in;
         den_ff <= len_ff;
         q4_ff  <= qsq_ff;
      end
   end

   // Divider: T = floor(K * 2^30 / L), with K and Q carried alongside.
   ssc_pkg::ctl_type           div_ctl;
   logic [ssc_pkg::QUO_W-1:0]  div_quo;
   logic [2*SQW-1:0]           div_side;

   ssc_div #(
      .NUM_W  (SQW),
      .QW     (ssc_pkg::QUO_W),
      .SIDE_W (2 * SQW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_ctl   (ctl4_ff),
      .in_num   (num_ff),
      .in_den   (den_ff),
      .in_side  ({q4_ff, num_ff}),
      .out_ctl  (div_ctl),
      .out_quo  (div_quo),
      .out_side (div_side)
   );

   // Stage 5: K * T as four partial products.
   logic [KLW-1:0] k_lo;
   logic [KHW-1:0] k_hi;
   logic [ssc_pkg::QUO_LO_W-1:0] t_lo;
   logic [ssc_pkg::QUO_HI_W-1:0] t_hi;

   assign k_lo = div_side[KLW-1:0];
   assign k_hi = div_side[SQW-1:KLW];
   assign t_lo = div_quo[ssc_pkg::QUO_LO_W-1:0];
   assign t_hi = div_quo[ssc_pkg::QUO_W-1:ssc_pkg::QUO_LO_W];

   ssc_pkg::ctl_type ctl5_ff;
   logic [KLW+ssc_pkg::QUO_LO_W-1:0] pp_ll_ff;
   logic [KLW+ssc_pkg::QUO_HI_W-1:0] pp_lh_ff;
   logic [KHW+ssc_pkg::QUO_LO_W-1:0] pp_hl_ff;
   logic [KHW+ssc_pkg::QUO_HI_W-1:0] pp_hh_ff;
   logic [SQW-1:0] q5_ff;

   // Stage 6: M = Q - floor(K * T / 2^30), placed as the radicand.
   logic [PW-1:0]  prod;
   logic [SQW-1:0] m_in;
   ssc_pkg::ctl_type ctl6_ff;
   logic [SIW-1:0] rad_ff;

   always_comb begin
      prod = PW'(pp_ll_ff)
           + (PW'(pp_lh_ff) << ssc_pkg::QUO_LO_W)
           + (PW'(pp_hl_ff) << KLW)
           + (PW'(pp_hh_ff) << (KLW + ssc_pkg::QUO_LO_W));
      m_in = q5_ff - SQW'(prod >> ssc_pkg::T_BITS);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl5_ff <= '0;
         ctl6_ff <= '0;
      end else if (adv) begin
         ctl5_ff <= div_ctl;
         ctl6_ff <= ctl5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ll_ff <= (KLW+ssc_pkg::QUO_LO_W)'(k_lo) * (KLW+ssc_pkg::QUO_LO_W)'(t_lo);
         pp_lh_ff <= (KLW+ssc_pkg::QUO_HI_W)'(k_lo) * (KLW+ssc_pkg::QUO_HI_W)'(t_hi);
         pp_hl_ff <= (KHW+ssc_pkg::QUO_LO_W)'(k_hi) * (KHW+ssc_pkg::QUO_LO_W)'(t_lo);
         pp_hh_ff <= (KHW+ssc_pkg::QUO_HI_W)'(k_hi) * (KHW+ssc_pkg::QUO_HI_W)'(t_hi);
         q5_ff    <= div_side[2*SQW-1:SQW];
         rad_ff   <= SIW'(m_in) << (2 * ssc_pkg::DIST_FRAC - 2 * FRAC_BITS);
      end
   end

   // Square root: distance in units of 1/256 pixel.
   ssc_pkg::ctl_type sq_ctl;
   logic [RW-1:0]    root_dist;

   ssc_sqrt #(
      .IN_W (SIW)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_ctl   (ctl6_ff),
      .in_val   (rad_ff),
      .out_ctl  (sq_ctl),
      .out_root (root_dist)
   );

   // Output stage: coverage = clamp((R + 256 - D) / 2, 0, 256), or 0 when force_zero is set.
   logic signed [XW-1:0] ramp;
   logic [XW-1:0]        half;
   logic [ssc_pkg::COV_W-1:0] cov_in, cov_ff;
   logic out_valid_in;

   always_comb begin
      ramp = $signed(XW'(radius_ff) << (ssc_pkg::DIST_FRAC - FRAC_BITS))
           + $signed(XW'(ssc_pkg::COV_FULL))
           - $signed(XW'(root_dist));
      half = XW'(ramp) >> 1;
      if (sq_ctl.force_zero || ramp[XW-1] || ramp == '0) begin
         cov_in = '0;
      end else if (half > XW'(ssc_pkg::COV_FULL)) begin
         cov_in = ssc_pkg::COV_FULL;
      end else begin
         cov_in = half[ssc_pkg::COV_W-1:0];
      end
      out_valid_in = sq_ctl.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cov_ff <= cov_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = ssc_pkg::RSP_W'(cov_ff);

   // The ramp clamp keeps every coverage word within one full pixel.
   a_cov_range: assert property (@(posedge clock)
      rsp_tvalid |-> (cov_ff <= ssc_pkg::COV_FULL))
      else $error("coverage above full scale");

   // A projection outside the segment always leaves as zero coverage.
   a_flat_end: assert property (@(posedge clock) disable iff (reset)
      (adv && sq_ctl.valid && sq_ctl.force_zero) |=> (rsp_tvalid && cov_ff == '0))
      else $error("flat end word gave nonzero coverage");

   // While the output is stalled the pipeline holds its words in place.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(ctl4_ff) && $stable(ctl6_ff) && $stable(sq_ctl)))
      else $error("pipeline moved during a stall");

   // Reset empties the output register.
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
`default_nettype wire
